### sv/bped_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bped_pkg
// Shared types, register indexes and reset values for the button press
// event detector.
// ----------------------------------------------------------------------------
package bped_pkg;

   localparam int MAX_EXTRA_READS_DEF = 15;
   localparam int TIME_BITS_DEF       = 32;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 31;

   localparam int REPEAT_BITS = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FILTER_MODE     = 3'd0,
      CSR_INVERT_INPUT    = 3'd1,
      CSR_EXTRA_READS     = 3'd2,
      CSR_SAMPLE_INTERVAL = 3'd3,
      CSR_STABLE_REPEATS  = 3'd4,
      CSR_DEBOUNCE        = 3'd5,
      CSR_LONG_PRESS      = 3'd6,
      CSR_TIMEOUT         = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      FILT_NONE  = 2'd0,
      FILT_AGREE = 2'd1,
      FILT_HARD  = 2'd2,
      FILT_OFF   = 2'd3
   } filter_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_PRESSED = 2'd1,
      ST_LONG    = 2'd2,
      ST_TIMEOUT = 2'd3
   } state_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PRESS   = 3'd1,
      EV_LONG    = 3'd2,
      EV_TIMEOUT = 3'd3,
      EV_CLICK   = 3'd4
   } event_type;

   localparam logic [1:0]  FILTER_MODE_RST     = 2'd0;
   localparam logic        INVERT_INPUT_RST    = 1'b1;
   localparam logic [3:0]  EXTRA_READS_RST     = 4'd3;
   localparam logic [15:0] SAMPLE_INTERVAL_RST = 16'd10;
   localparam logic [7:0]  STABLE_REPEATS_RST  = 8'd5;
   localparam logic [30:0] DEBOUNCE_RST        = 31'd50;
   localparam logic [30:0] LONG_PRESS_RST      = 31'd1000;
   localparam logic [30:0] TIMEOUT_RST         = 31'd10000;

endpackage
`default_nettype wire

### sv/button_press_event_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_press_event_detector
// Debounces polled button reads and reports press, long press, timeout and
// click events.
// ----------------------------------------------------------------------------
// One poll per transaction, one result per poll. A poll is captured in an
// input register, filtered and run through the press state machine as it
// moves into an output register, where the result sits until taken.
// A new poll is accepted every cycle while results are drained.
// Configuration writes take effect at once and are meant to be made while
// no poll is in flight.
module button_press_event_detector #(
   parameter int MAX_EXTRA_READS = bped_pkg::MAX_EXTRA_READS_DEF,
   parameter int TIME_BITS       = bped_pkg::TIME_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [31:0]                         req_now_ms,
   input  wire logic [31:0]                         req_pin_reads,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [2:0]                          rsp_event_code,
   output      logic [1:0]                          rsp_button_state,
   output      logic                                rsp_level_accepted,
   input  wire logic                                csr_write_en,
   input  wire logic [bped_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [bped_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import bped_pkg::*;

   localparam int TW = TIME_BITS;

   // configuration
   logic [1:0]             filter_mode_ff;
   logic                   invert_input_ff;
   logic [3:0]             extra_reads_ff;
   logic [15:0]            sample_interval_ff;
   logic [REPEAT_BITS-1:0] stable_repeats_ff;
   logic [30:0]            debounce_ff;
   logic [30:0]            long_press_ff;
   logic [30:0]            timeout_ff;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_now_ff;
   logic [31:0] in_pins_ff;

   // detector state
   logic [TW-1:0]          press_start_ff, press_start_in;
   state_type              state_ff, state_in;
   logic [TW-1:0]          last_sample_ff, last_sample_in;
   logic [REPEAT_BITS-1:0] repeat_count_ff, repeat_count_in;
   logic                   ref_valid_ff, ref_valid_in;
   logic                   ref_bit_ff, ref_bit_in;

   // output stage
   logic      out_valid_ff, out_valid_in;
   event_type out_event_ff, out_event_in;
   state_type out_state_ff;
   logic      out_accepted_ff;

   logic advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff     <= FILTER_MODE_RST;
         invert_input_ff    <= INVERT_INPUT_RST;
         extra_reads_ff     <= EXTRA_READS_RST;
         sample_interval_ff <= SAMPLE_INTERVAL_RST;
         stable_repeats_ff  <= STABLE_REPEATS_RST;
         debounce_ff        <= DEBOUNCE_RST;
         long_press_ff      <= LONG_PRESS_RST;
         timeout_ff         <= TIMEOUT_RST;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_FILTER_MODE:     filter_mode_ff     <= csr_wdata[1:0];
            CSR_INVERT_INPUT:    invert_input_ff    <= csr_wdata[0];
            CSR_EXTRA_READS:     extra_reads_ff     <= csr_wdata[3:0];
            CSR_SAMPLE_INTERVAL: sample_interval_ff <= csr_wdata[15:0];
            CSR_STABLE_REPEATS:  stable_repeats_ff  <= csr_wdata[REPEAT_BITS-1:0];
            CSR_DEBOUNCE:        debounce_ff        <= csr_wdata;
            CSR_LONG_PRESS:      long_press_ff      <= csr_wdata;
            CSR_TIMEOUT:         timeout_ff         <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // input filter
   // ------------------------------------------------------------------
   logic [TW-1:0] now_t;
   logic [TW-1:0] since_sample;
   logic [3:0]    n_extra;
   logic [4:0]    grp_len;
   logic [31:0]   grp_mask;
   logic [31:0]   g1_bits, g2_bits;
   logic          g1_ok, g2_ok;
   logic          v_ok, v_bit;
   logic          sample_due;
   logic          lvl_valid, lvl_bit;

   assign now_t        = in_now_ff[TW-1:0];
   assign since_sample = now_t - last_sample_ff;

   always_comb begin
      if (32'(extra_reads_ff) > MAX_EXTRA_READS) begin
         n_extra = 4'(MAX_EXTRA_READS);
      end else begin
         n_extra = extra_reads_ff;
      end
      grp_len  = {1'b0, n_extra} + 5'd1;
      grp_mask = ~(32'hFFFF_FFFF << grp_len);
      g1_bits  = in_pins_ff & grp_mask;
      g2_bits  = (in_pins_ff >> grp_len) & grp_mask;
      g1_ok    = (g1_bits == 32'd0) || (g1_bits == grp_mask);
      g2_ok    = (g2_bits == 32'd0) || (g2_bits == grp_mask);
   end

   always_comb begin
      sample_due      = 32'(since_sample) >= 32'(sample_interval_ff);
      last_sample_in  = last_sample_ff;
      repeat_count_in = repeat_count_ff;
      ref_valid_in    = ref_valid_ff;
      ref_bit_in      = ref_bit_ff;
      v_ok            = g1_ok;
      v_bit           = in_pins_ff[0];
      lvl_valid       = 1'b0;
      lvl_bit         = in_pins_ff[0];
      case (filter_mode_type'(filter_mode_ff))
         FILT_NONE: begin
            lvl_valid = 1'b1;
         end
         FILT_AGREE: begin
            lvl_valid = g1_ok;
         end
         FILT_HARD: begin
            if (sample_due) begin
               last_sample_in = now_t;
               if (repeat_count_ff == '0) begin
                  ref_valid_in = g1_ok;
                  ref_bit_in   = in_pins_ff[0];
                  v_ok         = g2_ok;
                  v_bit        = g2_bits[0];
               end
               if (!(v_ok && ref_valid_in && (v_bit == ref_bit_in))) begin
                  repeat_count_in = '0;
               end else if (repeat_count_ff == stable_repeats_ff) begin
                  repeat_count_in = '0;
                  lvl_valid       = 1'b1;
                  lvl_bit         = ref_bit_in;
               end else begin
                  repeat_count_in = repeat_count_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // press state machine
   // ------------------------------------------------------------------
   logic          pressed;
   logic [TW-1:0] elapsed;
   logic [31:0]   elapsed_ext;
   logic          started;

   assign pressed     = lvl_bit ^ invert_input_ff;
   assign elapsed     = now_t - press_start_ff;
   assign elapsed_ext = 32'(elapsed);
   assign started     = press_start_ff != '0;

   always_comb begin
      state_in       = state_ff;
      press_start_in = press_start_ff;
      if (lvl_valid) begin
         if (pressed) begin
            if (state_ff == ST_IDLE && !started) begin
               press_start_in = now_t;
            end else if (elapsed_ext > {1'b0, timeout_ff}) begin
               state_in = ST_TIMEOUT;
            end else if (elapsed_ext > {1'b0, long_press_ff}) begin
               state_in = ST_LONG;
            end else if (elapsed_ext > {1'b0, debounce_ff}) begin
               state_in = ST_PRESSED;
            end
         end else if (started) begin
            state_in       = ST_IDLE;
            press_start_in = '0;
         end
      end
   end

   always_comb begin
      out_event_in = EV_NONE;
      if (state_in != state_ff) begin
         case (state_in)
            ST_PRESSED: out_event_in = EV_PRESS;
            ST_LONG:    out_event_in = EV_LONG;
            ST_TIMEOUT: out_event_in = EV_TIMEOUT;
            default:    out_event_in = EV_NONE;
         endcase
      end
      if (lvl_valid && !pressed && started &&
          elapsed_ext > {1'b0, debounce_ff} && elapsed_ext < {1'b0, long_press_ff}) begin
         out_event_in = EV_CLICK;
      end
   end

   // ------------------------------------------------------------------
   // pipeline registers
   // ------------------------------------------------------------------
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         press_start_ff  <= '0;
         state_ff        <= ST_IDLE;
         last_sample_ff  <= '0;
         repeat_count_ff <= '0;
         ref_valid_ff    <= 1'b0;
         ref_bit_ff      <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            press_start_ff  <= press_start_in;
            state_ff        <= state_in;
            last_sample_ff  <= last_sample_in;
            repeat_count_ff <= repeat_count_in;
            ref_valid_ff    <= ref_valid_in;
            ref_bit_ff      <= ref_bit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_now_ff  <= req_now_ms;
         in_pins_ff <= req_pin_reads;
      end
      if (advance) begin
         out_event_ff    <= out_event_in;
         out_state_ff    <= state_in;
         out_accepted_ff <= lvl_valid;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_code     = out_event_ff;
   assign rsp_button_state   = out_state_ff;
   assign rsp_level_accepted = out_accepted_ff;

endmodule
`default_nettype wire

### verif/tb_button_press_event_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_button_press_event_detector
// Self-checking testbench for the button press event detector. Polls are
// driven over the request channel and every response is compared field by
// field with a cycle-free software model of the filter and press machine.
// Directed tests cover the press/long/timeout/click sequence, each filter
// mode and the threshold extremes. A back-pressure run follows, then random
// phases under random configurations, most with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_button_press_event_detector;
   import bped_pkg::*;

   localparam int          CYCLE_LIMIT  = 300000;
   localparam int          DRAIN_CYCLES = 6;
   localparam int          LONG_HOLD    = 150;
   localparam logic [1:0]  LVL_BAD      = 2'd3;
   localparam logic [30:0] THRESH_MAX   = 31'h7FFF_FFFF;

   typedef struct {
      event_type ev;
      state_type st;
      logic      acc;
   } button_report_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [31:0]               req_now_ms;
   logic [31:0]               req_pin_reads;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [2:0]                rsp_event_code;
   logic [1:0]                rsp_button_state;
   logic                      rsp_level_accepted;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // model copy of the registers
   filter_mode_type m_mode;
   logic            m_invert;
   logic [3:0]      m_extra;
   logic [15:0]     m_interval;
   logic [7:0]      m_repeats;
   logic [30:0]     m_debounce;
   logic [30:0]     m_long;
   logic [30:0]     m_timeout;

   // model copy of the state
   logic [31:0]     m_press_start;
   state_type       m_state;
   logic [31:0]     m_last_sample;
   logic [7:0]      m_repeat_count;
   logic [1:0]      m_ref_level;

   button_report_type pending_reports[$];

   int unsigned     mismatch_count;
   int unsigned     polls_sent;
   int unsigned     reports_checked;
   int unsigned     events_seen[5];
   int unsigned     cycle_count;
   int unsigned     hold_cycles;
   bit              sender_idle_on;
   bit              receiver_stall_on;
   logic [31:0]     poll_time;

   button_press_event_detector u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_now_ms         (req_now_ms),
      .req_pin_reads      (req_pin_reads),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_code     (rsp_event_code),
      .rsp_button_state   (rsp_button_state),
      .rsp_level_accepted (rsp_level_accepted),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [1:0] read_group(input logic [31:0] bits, inout int pos);
      logic first;
      logic b;
      int   i;
      first = (pos < 32) ? bits[pos] : 1'b0;
      pos++;
      for (i = 0; i < m_extra; i++) begin
         b = (pos < 32) ? bits[pos] : 1'b0;
         pos++;
         if (b != first) begin
            return LVL_BAD;
         end
      end
      return {1'b0, first};
   endfunction

   task automatic predict_button_event(input logic [31:0] now, input logic [31:0] bits);
      int                pos;
      logic [1:0]        lvl;
      logic [1:0]        v;
      logic [7:0]        old;
      logic [31:0]       elapsed;
      logic              pressed;
      button_report_type r;
      pos   = 0;
      lvl   = LVL_BAD;
      r.ev  = EV_NONE;
      r.acc = 1'b0;
      case (m_mode)
         FILT_NONE: begin
            lvl = {1'b0, bits[0]};
         end
         FILT_AGREE: begin
            lvl = read_group(bits, pos);
         end
         FILT_HARD: begin
            if (now - m_last_sample >= {16'd0, m_interval}) begin
               m_last_sample = now;
               if (m_repeat_count == 8'd0) begin
                  m_ref_level = read_group(bits, pos);
               end
               v = read_group(bits, pos);
               if (v != m_ref_level || v == LVL_BAD) begin
                  m_repeat_count = 8'd0;
               end else begin
                  old            = m_repeat_count;
                  m_repeat_count = m_repeat_count + 8'd1;
                  if (old == m_repeats) begin
                     m_repeat_count = 8'd0;
                     lvl            = m_ref_level;
                  end
               end
            end
         end
         default: ;
      endcase
      if (lvl != LVL_BAD) begin
         r.acc   = 1'b1;
         pressed = lvl[0] ^ m_invert;
         elapsed = now - m_press_start;
         if (pressed) begin
            if (m_state == ST_IDLE && m_press_start == 32'd0) begin
               m_press_start = now;
            end else if (elapsed > {1'b0, m_timeout}) begin
               if (m_state != ST_TIMEOUT) begin
                  m_state = ST_TIMEOUT;
                  r.ev    = EV_TIMEOUT;
               end
            end else if (elapsed > {1'b0, m_long}) begin
               if (m_state != ST_LONG) begin
                  m_state = ST_LONG;
                  r.ev    = EV_LONG;
               end
            end else if (elapsed > {1'b0, m_debounce}) begin
               if (m_state != ST_PRESSED) begin
                  m_state = ST_PRESSED;
                  r.ev    = EV_PRESS;
               end
            end
         end else if (m_press_start != 32'd0) begin
            if (elapsed > {1'b0, m_debounce} && elapsed < {1'b0, m_long}) begin
               r.ev = EV_CLICK;
            end
            m_state       = ST_IDLE;
            m_press_start = 32'd0;
         end
      end
      r.st = m_state;
      pending_reports.push_back(r);
   endtask

   task automatic reset_model();
      m_mode         = filter_mode_type'(FILTER_MODE_RST);
      m_invert       = INVERT_INPUT_RST;
      m_extra        = EXTRA_READS_RST;
      m_interval     = SAMPLE_INTERVAL_RST;
      m_repeats      = STABLE_REPEATS_RST;
      m_debounce     = DEBOUNCE_RST;
      m_long         = LONG_PRESS_RST;
      m_timeout      = TIMEOUT_RST;
      m_press_start  = 32'd0;
      m_state        = ST_IDLE;
      m_last_sample  = 32'd0;
      m_repeat_count = 8'd0;
      m_ref_level    = LVL_BAD;
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic write_csr(input csr_index_type idx, input logic [30:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FILTER_MODE:     m_mode     = filter_mode_type'(val[1:0]);
         CSR_INVERT_INPUT:    m_invert   = val[0];
         CSR_EXTRA_READS:     m_extra    = val[3:0];
         CSR_SAMPLE_INTERVAL: m_interval = val[15:0];
         CSR_STABLE_REPEATS:  m_repeats  = val[7:0];
         CSR_DEBOUNCE:        m_debounce = val;
         CSR_LONG_PRESS:      m_long     = val;
         CSR_TIMEOUT:         m_timeout  = val;
         default: ;
      endcase
   endtask

   task automatic write_thresholds(input logic [30:0] deb, input logic [30:0] lp,
                                   input logic [30:0] to);
      write_csr(CSR_DEBOUNCE, deb);
      write_csr(CSR_LONG_PRESS, lp);
      write_csr(CSR_TIMEOUT, to);
   endtask

   // Leaves req_valid high at the accepting edge; the next call drives its own
   // poll or gap, or wait_idle lowers it, in that same step.
   task automatic send_poll(input logic [31:0] now, input logic [31:0] bits);
      int unsigned gap;
      if (sender_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_now_ms    <= now;
      req_pin_reads <= bits;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      predict_button_event(now, bits);
      polls_sent++;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      int unsigned n;
      rsp_ready <= 1'b0;
      forever begin
         if (hold_cycles != 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (receiver_stall_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0d, expected %0d (poll %0d)", what, got, want,
               reports_checked);
      mismatch_count++;
   endtask

   always @(negedge clock) begin : check_reports
      button_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected response", {29'd0, rsp_event_code}, 0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_event_code !== want.ev) begin
               report_mismatch("event_code", {29'd0, rsp_event_code}, {29'd0, want.ev});
            end
            if (rsp_button_state !== want.st) begin
               report_mismatch("button_state", {30'd0, rsp_button_state},
                               {30'd0, want.st});
            end
            if (rsp_level_accepted !== want.acc) begin
               report_mismatch("level_accepted", {31'd0, rsp_level_accepted},
                               {31'd0, want.acc});
            end
            events_seen[want.ev]++;
            reports_checked++;
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   // reset configuration: no filter, active low pin
   task automatic test_press_sequence();
      send_poll(32'd0, 32'h0);           // press at time zero stays not started
      send_poll(32'd100, 32'h0);
      send_poll(32'd120, 32'h0);
      send_poll(32'd200, 32'h0);
      send_poll(32'd1200, 32'h0);
      send_poll(32'd1300, 32'h0);        // already long press
      send_poll(32'd20000, 32'h0);
      send_poll(32'd20010, 32'h1);       // release after timeout, no click
      send_poll(32'd20020, 32'h1);       // release while not started
      send_poll(32'd30000, 32'h0);
      send_poll(32'd30100, 32'h0);
      send_poll(32'd30200, 32'hFFFF_FFFF); // click
      send_poll(32'hFFFF_FF00, 32'hFFFF_FFFE);
      send_poll(32'h0000_0100, 32'h0);   // elapsed across wrap
      send_poll(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_idle();
   endtask

   task automatic test_agree_filter();
      write_csr(CSR_FILTER_MODE, 31'(FILT_AGREE));
      write_csr(CSR_EXTRA_READS, 31'd0);
      send_poll(32'd40000, 32'h1);
      wait_idle();
      write_csr(CSR_EXTRA_READS, 31'd15);
      send_poll(32'd40010, 32'h0000_FFFF);
      send_poll(32'd40020, 32'h0000_7FFF); // one read disagrees
      send_poll(32'd40100, 32'h0);
      wait_idle();
      write_csr(CSR_EXTRA_READS, 31'd3);
      send_poll(32'd40110, 32'h0000_000E);
      wait_idle();
   endtask

   task automatic test_hard_filter();
      write_csr(CSR_FILTER_MODE, 31'(FILT_HARD));
      write_csr(CSR_EXTRA_READS, 31'd1);
      write_csr(CSR_SAMPLE_INTERVAL, 31'd10);
      write_csr(CSR_STABLE_REPEATS, 31'd2);
      send_poll(32'd50000, 32'h0);
      send_poll(32'd50010, 32'h0);
      send_poll(32'd50015, 32'h0);       // too soon
      send_poll(32'd50020, 32'h0);
      send_poll(32'd50030, 32'h4);       // broken second group
      wait_idle();
      write_csr(CSR_SAMPLE_INTERVAL, 31'd0);
      write_csr(CSR_STABLE_REPEATS, 31'd0);
      send_poll(32'd50031, 32'hF);
      wait_idle();
      write_csr(CSR_SAMPLE_INTERVAL, 31'd65535);
      write_csr(CSR_STABLE_REPEATS, 31'd254);
      send_poll(32'd50032, 32'h0);
      wait_idle();
      write_csr(CSR_STABLE_REPEATS, 31'd255);
      send_poll(32'd120000, 32'h0);
      wait_idle();
   endtask

   task automatic test_unused_mode();
      write_csr(CSR_FILTER_MODE, 31'(FILT_OFF));
      send_poll(32'd130000, 32'h0);
      send_poll(32'd130500, 32'hFFFF_FFFF);
      wait_idle();
   endtask

   task automatic test_threshold_extremes();
      write_csr(CSR_FILTER_MODE, 31'(FILT_NONE));
      write_csr(CSR_INVERT_INPUT, 31'd0);
      write_thresholds(31'd0, 31'd0, 31'd0);
      send_poll(32'd5000, 32'h1);
      send_poll(32'd5001, 32'h1);
      send_poll(32'd5002, 32'h0);
      wait_idle();
      write_thresholds(THRESH_MAX, THRESH_MAX, THRESH_MAX);
      send_poll(32'd6000, 32'h1);
      send_poll(32'd0, 32'h1);           // elapsed above the 31-bit range
      send_poll(32'd6100, 32'h0);
      wait_idle();
   endtask

   task automatic test_backpressure();
      int k;
      write_csr(CSR_INVERT_INPUT, 31'd1);
      write_thresholds(31'd20, 31'd100, 31'd300);
      sender_idle_on    = 1'b0;
      receiver_stall_on = 1'b0;
      hold_cycles       = LONG_HOLD;
      poll_time         = 32'd200000;
      for (k = 0; k < 30; k++) begin
         poll_time += 32'd9;
         send_poll(poll_time, (k % 12 < 9) ? 32'h0 : 32'hFFFF_FFFF);
      end
      wait_idle();
   endtask

   function automatic logic [31:0] noisy_reads(input bit level);
      logic [31:0] bits;
      bits = level ? 32'hFFFF_FFFF : 32'h0;
      case ($urandom_range(0, 9))
         0, 1:    bits = $urandom;
         2:       bits[$urandom_range(0, 31)] = ~level;
         default: ;
      endcase
      return bits;
   endfunction

   task automatic test_random_polls();
      int unsigned phase;
      int unsigned k;
      int unsigned run;
      int unsigned pick;
      logic [30:0] deb;
      logic [30:0] lp;
      bit          level;
      run   = 0;
      level = 1'b0;
      for (phase = 0; phase < 6; phase++) begin
         pick = $urandom_range(0, 9);
         write_csr(CSR_FILTER_MODE, 31'((pick < 3) ? FILT_NONE : (pick < 6) ? FILT_AGREE :
                                        (pick < 9) ? FILT_HARD : FILT_OFF));
         write_csr(CSR_INVERT_INPUT, 31'($urandom_range(0, 1)));
         write_csr(CSR_EXTRA_READS, 31'($urandom_range(0, 15)));
         write_csr(CSR_SAMPLE_INTERVAL, 31'($urandom_range(0, 40)));
         write_csr(CSR_STABLE_REPEATS, 31'($urandom_range(0, 4)));
         deb = 31'($urandom_range(0, 100));
         lp  = deb + 31'($urandom_range(0, 600));
         write_thresholds(deb, lp, lp + 31'($urandom_range(0, 1500)));
         sender_idle_on    = (phase < 5);
         receiver_stall_on = (phase < 5);
         if (phase == 3) begin
            poll_time = 32'hFFFF_F000;
         end
         for (k = 0; k < 85; k++) begin
            if (run == 0) begin
               level = 1'($urandom_range(0, 1));
               run   = $urandom_range(1, 60);
            end
            run--;
            case ($urandom_range(0, 39))
               0:       poll_time = $urandom;
               1:       poll_time = 32'd0;
               2:       ;
               default: poll_time += $urandom_range(1, 60);
            endcase
            send_poll(poll_time, noisy_reads(level));
         end
         wait_idle();
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_now_ms    <= 32'd0;
      req_pin_reads <= 32'd0;
      csr_write_en  <= 1'b0;
      csr_index     <= CSR_FILTER_MODE;
      csr_wdata     <= '0;
      mismatch_count    = 0;
      polls_sent        = 0;
      reports_checked   = 0;
      hold_cycles       = 0;
      sender_idle_on    = 1'b1;
      receiver_stall_on = 1'b1;
      poll_time         = 32'd0;
      foreach (events_seen[i]) events_seen[i] = 0;
      reset_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_press_sequence();
      test_agree_filter();
      test_hard_filter();
      test_unused_mode();
      test_threshold_extremes();
      test_backpressure();
      test_random_polls();

      $display("Ran %0d polls through all filter modes, %0d responses checked",
               polls_sent, reports_checked);
      $display("Events: press %0d, long %0d, timeout %0d, click %0d",
               events_seen[EV_PRESS], events_seen[EV_LONG], events_seen[EV_TIMEOUT],
               events_seen[EV_CLICK]);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire

### files.f
sv/bped_pkg.sv
sv/button_press_event_detector.sv
verif/tb_button_press_event_detector.sv
